@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

`define ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)

`endif

`endif

@@ hdl/trlq_pkg.sv @@
// ----------------------------------------------------------------------------
// trlq_pkg
// Types, codes and timestamp helpers for the timestamp range log query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trlq_pkg;

   localparam int DEFAULT_ENTRIES = 64;

   localparam int ID_W   = 32;
   localparam int TIME_W = 40;

   // packed timestamp field positions (low bit of each field)
   localparam int SHIFT_YEAR   = 26;
   localparam int SHIFT_MONTH  = 22;
   localparam int SHIFT_DAY    = 17;
   localparam int SHIFT_HOUR   = 12;
   localparam int SHIFT_MINUTE = 6;
   localparam int SHIFT_SECOND = 0;

   localparam logic CMD_APPEND   = 1'b0;
   localparam logic CMD_RETRIEVE = 1'b1;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_MATCH = 2'd1;
   localparam logic [1:0] KIND_NONE  = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam logic [2:0] GRAN_NONE   = 3'd0;
   localparam logic [2:0] GRAN_YEAR   = 3'd1;
   localparam logic [2:0] GRAN_MONTH  = 3'd2;
   localparam logic [2:0] GRAN_DAY    = 3'd3;
   localparam logic [2:0] GRAN_HOUR   = 3'd4;
   localparam logic [2:0] GRAN_MINUTE = 3'd5;
   localparam logic [2:0] GRAN_SECOND = 3'd6;
   localparam logic [2:0] GRAN_UNUSED = 3'd7;

   typedef struct packed {
      logic                     command;
      logic signed [ID_W-1:0]   entry_id;
      logic        [TIME_W-1:0] time_or_start;
      logic        [TIME_W-1:0] end_time;
      logic        [2:0]        granularity;
   } req_type;

   typedef struct packed {
      logic        [1:0]      kind;
      logic                   status;
      logic signed [ID_W-1:0] match_id;
      logic                   is_last;
   } rsp_type;

   typedef struct packed {
      logic signed [ID_W-1:0]   id;
      logic        [TIME_W-1:0] stamp;
   } entry_type;

   // bits of a timestamp that take part in the compare; zero mask matches all
   function automatic logic [TIME_W-1:0] gran_mask(input logic [2:0] gran);
      logic [TIME_W-1:0] ones;
      ones = {TIME_W{1'b1}};
      case (gran) inside
         GRAN_NONE, GRAN_UNUSED: gran_mask = '0;
         GRAN_YEAR:              gran_mask = ones << SHIFT_YEAR;
         GRAN_MONTH:             gran_mask = ones << SHIFT_MONTH;
         GRAN_DAY:               gran_mask = ones << SHIFT_DAY;
         GRAN_HOUR:              gran_mask = ones << SHIFT_HOUR;
         GRAN_MINUTE:            gran_mask = ones << SHIFT_MINUTE;
         GRAN_SECOND:            gran_mask = ones << SHIFT_SECOND;
         default:                gran_mask = '0;
      endcase
   endfunction

endpackage

@@ hdl/trlq_store.sv @@
// ----------------------------------------------------------------------------
// trlq_store
// Entry table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trlq_store #(
   parameter int ENTRIES = trlq_pkg::DEFAULT_ENTRIES,
   parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  trlq_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output trlq_pkg::entry_type rd_data
);

   trlq_pkg::entry_type mem [ENTRIES];
   trlq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/timestamp_range_log_query.sv @@
// ----------------------------------------------------------------------------
// timestamp_range_log_query
// Log table of (id, timestamp) entries with append and time-range retrieve.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready): one command per beat. Append stores the id
//   and timestamp at the end of the table; retrieve scans the table for
//   timestamps inside [start, end], compared at the given granularity.
//   rsp channel (valid/ready): append gives one acknowledge beat (status
//   set when the table was full and the entry dropped). Retrieve gives one
//   beat per matching id in append order, is_last on the final one, or a
//   single no-match beat.
//   The append ack passes the ACK state and then the output register. A
//   retrieve checks one stored entry per cycle while rsp is not stalled,
//   limited by the single read port of the entry table.
//   A new command is accepted only once the previous one has issued all of
//   its result beats; the last beat may still sit in the output register.
//   A rsp stall freezes the scan only on a matching entry, while the earlier match cannot move.
//   Reset empties the table (entry count to zero).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module timestamp_range_log_query #(
   parameter int ENTRIES = trlq_pkg::DEFAULT_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  trlq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output trlq_pkg::rsp_type rsp_data
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ACK  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                        state_ff, state_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    iss_ff, iss_in;
   logic                             chk_vld_ff, chk_vld_in;
   logic [AW-1:0]                    chk_addr_ff, chk_addr_in;
   logic                             pend_vld_ff, pend_vld_in;
   logic signed [trlq_pkg::ID_W-1:0] pend_id_ff, pend_id_in;
   logic [trlq_pkg::TIME_W-1:0]      lo_ff, lo_in;
   logic [trlq_pkg::TIME_W-1:0]      hi_ff, hi_in;
   logic [trlq_pkg::TIME_W-1:0]      mask_ff, mask_in;
   logic                             full_ff, full_in;
   trlq_pkg::rsp_type                rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   trlq_pkg::entry_type              wr_data;
   trlq_pkg::entry_type              rd_data;
   logic                             wr_en;
   logic [AW-1:0]                    rd_addr;
   logic [trlq_pkg::TIME_W-1:0]      tm;
   logic                             accept;
   logic                             can_push;
   logic                             hit;
   logic                             stall;
   logic                             issue;
   logic                             is_full;
   logic                             push;
   trlq_pkg::rsp_type                push_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign can_push  = !rsp_valid_ff || rsp_ready;
   assign is_full   = (count_ff == FULL_COUNT);

   assign tm    = rd_data.stamp & mask_ff;
   assign hit   = chk_vld_ff && (tm >= lo_ff) && (tm <= hi_ff);
   assign stall = hit && pend_vld_ff && !can_push;
   assign issue = (state_ff == ST_SCAN) && !stall && (iss_ff != count_ff);

   assign rd_addr = stall ? chk_addr_ff : iss_ff[AW-1:0];

   assign wr_en          = accept && (req_data.command == trlq_pkg::CMD_APPEND) && !is_full;
   assign wr_data.id     = req_data.entry_id;
   assign wr_data.stamp  = req_data.time_or_start;

   trlq_store #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      iss_in      = iss_ff;
      chk_vld_in  = chk_vld_ff;
      chk_addr_in = chk_addr_ff;
      pend_vld_in = pend_vld_ff;
      pend_id_in  = pend_id_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mask_in     = mask_ff;
      full_in     = full_ff;
      push        = 1'b0;
      push_data   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.command == trlq_pkg::CMD_APPEND) begin
                  full_in  = is_full;
                  state_in = ST_ACK;
                  if (!is_full) begin
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  mask_in     = trlq_pkg::gran_mask(req_data.granularity);
                  lo_in       = req_data.time_or_start & trlq_pkg::gran_mask(req_data.granularity);
                  hi_in       = req_data.end_time & trlq_pkg::gran_mask(req_data.granularity);
                  iss_in      = '0;
                  chk_vld_in  = 1'b0;
                  pend_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_ACK: begin
            if (can_push) begin
               push              = 1'b1;
               push_data.kind    = trlq_pkg::KIND_ACK;
               push_data.status  = full_ff ? trlq_pkg::STATUS_FULL : trlq_pkg::STATUS_OK;
               push_data.is_last = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               chk_vld_in = issue;
               if (issue) begin
                  chk_addr_in = iss_ff[AW-1:0];
                  iss_in      = iss_ff + 1'b1;
               end
               if (hit) begin
                  if (pend_vld_ff) begin
                     push               = 1'b1;
                     push_data.kind     = trlq_pkg::KIND_MATCH;
                     push_data.match_id = pend_id_ff;
                  end
                  pend_vld_in = 1'b1;
                  pend_id_in  = rd_data.id;
               end
               if (iss_ff == count_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (can_push) begin
               push              = 1'b1;
               push_data.is_last = 1'b1;
               if (pend_vld_ff) begin
                  push_data.kind     = trlq_pkg::KIND_MATCH;
                  push_data.match_id = pend_id_ff;
               end else begin
                  push_data.kind = trlq_pkg::KIND_NONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_in       = push_data;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         iss_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_ff       <= iss_in;
         chk_vld_ff   <= chk_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff <= chk_addr_in;
      pend_id_ff  <= pend_id_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mask_ff     <= mask_in;
      full_ff     <= full_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL_COUNT)
   `ASSERT_ALWAYS(a_issue_bound, clock, reset, iss_ff <= count_ff)
   `ASSERT_NEXT(a_stall_hold, clock, reset, stall, chk_vld_ff && $stable(chk_addr_ff))
   `ASSERT_NEXT(a_none_found, clock, reset, (state_ff == ST_DONE) && can_push && !pend_vld_ff, rsp_valid_ff && (rsp_ff.kind == trlq_pkg::KIND_NONE) && rsp_ff.is_last)

endmodule
